// File: rtl/tmsd_pkg.sv
// Shared types and constants of the two-sided multiset difference block.
`timescale 1ns / 1ps
package tmsd_pkg;

    localparam logic [1:0] KIND_ASSIGN   = 2'd0;
    localparam logic [1:0] KIND_UNASSIGN = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;

    localparam logic [1:0] STATUS_FAIL = 2'd0;
    localparam logic [1:0] STATUS_PASS = 2'd1;
    localparam logic [1:0] STATUS_NEW  = 2'd2;

    localparam logic [4:0] COUNT_MAX = 5'd31;

    // One excess table entry; a count of zero marks a free entry.
    typedef struct packed {
        logic        side;
        logic [31:0] value;
        logic [4:0]  count;
    } t_entry;

    // What one pass over the table has found.
    typedef struct packed {
        logic        lose_hit;
        logic        gain_hit;
        logic        free_hit;
        logic        min_hit;
        logic [4:0]  lose_cnt;
        logic [4:0]  gain_cnt;
        logic [31:0] min_val;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// File: rtl/tmsd_scan_unit.sv
// Shared compare unit that evaluates one table entry per cycle during a scan.
`timescale 1ns / 1ps
module tmsd_scan_unit
    import tmsd_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_ev,
    input  t_entry                         i_entry,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_idx,
    input  logic                           i_lose,
    input  logic                           i_gain,
    input  logic [31:0]                    i_key,
    output t_scan_flags                    o_flags,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_lose_idx,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_gain_idx,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_free_idx
);

    t_scan_flags r_flags;
    logic        occupied;
    logic        key_eq;

    assign occupied = (i_entry.count != 5'd0);
    assign key_eq   = (i_entry.value == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else if (i_ev) begin
            if (occupied && i_entry.side == i_lose && key_eq && !r_flags.lose_hit) begin
                r_flags.lose_hit <= 1'b1;
                r_flags.lose_cnt <= i_entry.count;
                o_lose_idx       <= i_idx;
            end
            if (occupied && i_entry.side == i_gain && key_eq && !r_flags.gain_hit) begin
                r_flags.gain_hit <= 1'b1;
                r_flags.gain_cnt <= i_entry.count;
                o_gain_idx       <= i_idx;
            end
            if (!occupied && !r_flags.free_hit) begin
                r_flags.free_hit <= 1'b1;
                o_free_idx       <= i_idx;
            end
            // Smallest value of the watched side that is not below the key.
            if (occupied && i_entry.side == i_lose && i_entry.value >= i_key &&
                (!r_flags.min_hit || i_entry.value < r_flags.min_val)) begin
                r_flags.min_hit <= 1'b1;
                r_flags.min_val <= i_entry.value;
            end
        end
    end

    assign o_flags = r_flags;

endmodule

// File: rtl/two_sided_multiset_difference_top.sv
// Top level of the two-sided multiset difference tracker.
//
// Items arrive on the s_axis channel: tuser carries the kind (assign,
// unassign, query), tdata carries side, slot and value. Every item gives
// exactly one result transaction on m_axis: tuser carries the status and
// tdata the next value. The block handles one item at a time and drops
// s_axis_tready while it works.
// An in-range assign writes the slot store and an in-range unassign reads
// it; either then scans the excess table one entry per cycle through a
// shared compare unit and finally writes back at most one entry. A query
// whose opposite side is completely filled scans the table the same way;
// any other item goes straight to its result. The table scan reads
// through the single memory read port of the excess table.
// After reset the block sweeps the excess table to mark every entry free,
// during which no item is accepted; APB writes are taken at any time.
// slots_in_use resets to 16.
// A finished result waits in an output register while the receiver stalls;
// the next item may be accepted meanwhile, but its result holds back until
// the output register is free.
`timescale 1ns / 1ps
module two_sided_multiset_difference_top
    import tmsd_pkg::*;
#(
    parameter int MAX_SLOTS   = 16,
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port, register slots_in_use at address 0
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // side [0], slot [4:1], value [36:5], zero pad
    input  logic [1:0]  s_axis_tuser,  // kind [1:0]
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // next_value [31:0]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int IW  = $clog2(TABLE_DEPTH + 1);
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW  = $clog2(MAX_SLOTS + 1);
    localparam int CW  = (FW > 5) ? FW : 5;
    localparam logic [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);
    localparam logic [CW-1:0] MAX_C   = CW'(MAX_SLOTS);
    localparam logic [FW-1:0] MAX_F   = FW'(MAX_SLOTS);

    // Configuration register.
    logic [4:0] r_slots;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {27'd0, r_slots} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= 5'd16;
        end else if (cfg_wr) begin
            r_slots <= pwdata[4:0];
        end
    end

    // Input fields.
    logic          in_side;
    logic [3:0]    in_slot;
    logic [31:0]   in_value;
    logic [CW-1:0] eff_slots;
    logic          in_range;
    logic [SW-1:0] in_slot_idx;

    assign in_side     = s_axis_tdata[0];
    assign in_slot     = s_axis_tdata[4:1];
    assign in_value    = s_axis_tdata[36:5];
    assign in_slot_idx = SW'(in_slot);
    // The usable slot count is the register clamped to MAX_SLOTS.
    assign eff_slots   = (CW'(r_slots) > MAX_C) ? MAX_C : CW'(r_slots);
    assign in_range    = (CW'(in_slot) < eff_slots);

    // State.
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic [1:0]    r_kind;
    logic          r_side;
    logic [31:0]   r_val;
    logic [31:0]   r_key;
    logic [FW-1:0] r_filled [2];
    logic [1:0]    r_res_status, n_res_status;
    logic [31:0]   r_res_value, n_res_value;
    logic          r_ov;
    logic [1:0]    r_ostatus;
    logic [31:0]   r_ovalue;

    // Slot store memory.
    logic [31:0] r_slotmem [2][MAX_SLOTS];
    logic [31:0] r_slot_rd;

    // Excess table memory.
    t_entry        r_tab [TABLE_DEPTH];
    t_entry        r_tab_rd;
    logic          tab_we;
    logic [AW-1:0] tab_wa;
    t_entry        tab_wd;

    // Scan unit connections.
    t_scan_flags   flags;
    logic [AW-1:0] lose_idx, gain_idx, free_idx;
    logic          scan_start;
    logic          lose_side, gain_side;
    logic          accept;
    logic          done_load;
    logic          issue;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign issue         = (r_state == ST_SCAN) && (r_idx != DEPTH_I);
    assign lose_side     = (r_kind == KIND_UNASSIGN) ? r_side : ~r_side;
    assign gain_side     = ~lose_side;

    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tuser == KIND_ASSIGN && in_range) begin
            r_slotmem[in_side][in_slot_idx] <= in_value;
        end
        r_slot_rd <= r_slotmem[in_side][in_slot_idx];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_wa] <= tab_wd;
        end
        r_tab_rd <= r_tab[r_idx[AW-1:0]];
    end

    tmsd_scan_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_ev       (r_pend),
        .i_entry    (r_tab_rd),
        .i_idx      (r_pidx),
        .i_lose     (lose_side),
        .i_gain     (gain_side),
        .i_key      (r_key),
        .o_flags    (flags),
        .o_lose_idx (lose_idx),
        .o_gain_idx (gain_idx),
        .o_free_idx (free_idx)
    );

    // Sequencer: next state, table writes and the result.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        tab_we       = 1'b0;
        tab_wa       = r_idx[AW-1:0];
        tab_wd       = '0;
        scan_start   = 1'b0;
        done_load    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                tab_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == DEPTH_I - 1'b1) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_res_status = STATUS_PASS;
                    n_res_value  = in_value;
                    n_idx        = '0;
                    n_state      = ST_DONE;
                    priority case (s_axis_tuser)
                        KIND_ASSIGN: begin
                            if (in_range) begin
                                n_state    = ST_SCAN;
                                scan_start = 1'b1;
                            end
                        end
                        KIND_UNASSIGN: begin
                            if (in_range) begin
                                n_state = ST_READ;
                            end
                        end
                        KIND_QUERY: begin
                            if (CW'(r_filled[~in_side]) == eff_slots) begin
                                n_state    = ST_SCAN;
                                scan_start = 1'b1;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state    = ST_SCAN;
                scan_start = 1'b1;
            end
            ST_SCAN: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end else if (!r_pend) begin
                    if (r_kind == KIND_QUERY) begin
                        n_state = ST_DONE;
                        if (!flags.min_hit) begin
                            n_res_status = STATUS_FAIL;
                        end else if (flags.min_val != r_val) begin
                            n_res_status = STATUS_NEW;
                            n_res_value  = flags.min_val;
                        end
                    end else begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                n_state = ST_DONE;
                // Cancel an excess of the losing side first, else grow the gaining side.
                if (flags.lose_hit) begin
                    tab_we = 1'b1;
                    tab_wa = lose_idx;
                    tab_wd = '{side: lose_side, value: r_key, count: flags.lose_cnt - 1'b1};
                end else if (flags.gain_hit) begin
                    tab_we = (flags.gain_cnt < COUNT_MAX);
                    tab_wa = gain_idx;
                    tab_wd = '{side: gain_side, value: r_key, count: flags.gain_cnt + 1'b1};
                end else if (flags.free_hit) begin
                    tab_we = 1'b1;
                    tab_wa = free_idx;
                    tab_wd = '{side: gain_side, value: r_key, count: 5'd1};
                end
            end
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    done_load = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_filled[0] <= '0;
            r_filled[1] <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= issue;
            if (accept && in_range) begin
                if (s_axis_tuser == KIND_ASSIGN && r_filled[in_side] < MAX_F) begin
                    r_filled[in_side] <= r_filled[in_side] + 1'b1;
                end
                if (s_axis_tuser == KIND_UNASSIGN && r_filled[in_side] != '0) begin
                    r_filled[in_side] <= r_filled[in_side] - 1'b1;
                end
            end
            if (done_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pidx       <= r_idx[AW-1:0];
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (accept) begin
            r_kind <= s_axis_tuser;
            r_side <= in_side;
            r_val  <= in_value;
            r_key  <= in_value;
        end
        if (r_state == ST_READ) begin
            r_key <= r_slot_rd;
        end
        if (done_load) begin
            r_ostatus <= r_res_status;
            r_ovalue  <= r_res_value;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_ovalue;
    assign m_axis_tuser  = r_ostatus;

    // Assertions.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == ST_IDLE))
        else $error("input ready outside idle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filled[0] <= MAX_F) && (r_filled[1] <= MAX_F))
        else $error("fill count above slot count");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |-> !done_load)
        else $error("result loaded over a stalled result");

    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == ST_SCAN))
        else $error("table read pending outside scan");

endmodule
